[hdl/gcl_pkg.sv]
// shared types, codes and constants of the gaussian class likelihood block
// no dependencies

package gcl_pkg;

  localparam int DataW         = 32;
  localparam int MulW          = DataW + 1;
  localparam int LikW          = 48;
  localparam int ExpBits       = 22;
  localparam int ExpBitW       = $clog2(ExpBits);
  localparam int CfgIdxW       = 1;
  localparam int CfgW          = 4;
  localparam int MaxFeaturesDef = 8;
  localparam int MaxClassesDef  = 8;

  // request types
  localparam logic [1:0] ReqMean    = 2'd0;
  localparam logic [1:0] ReqCov     = 2'd1;
  localparam logic [1:0] ReqScale   = 2'd2;
  localparam logic [1:0] ReqFeature = 2'd3;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgFeatures = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgClasses  = 1'b1;

  typedef struct packed {
    logic                   en;
    logic signed [MulW-1:0] a;
    logic signed [MulW-1:0] b;
  } gcl_mul_req_t;

  // exp(-2^(b-17)) in q0.64, by repeated squaring of the first weight
  function automatic logic [ExpBits-1:0][63:0] exp_weight_table();
    logic [ExpBits-1:0][63:0] tab;
    logic [127:0]             sq;
    logic [63:0]              w;
    w = 64'hFFFF_8000_1FFF_FAAB;
    for (int k = 0; k < ExpBits; k++) begin
      tab[k] = w;
      sq     = {64'd0, w} * {64'd0, w};
      w      = sq[127:64];
    end
    return tab;
  endfunction

  localparam logic [ExpBits-1:0][63:0] ExpWeights = exp_weight_table();

endpackage

[hdl/gcl_mul.sv]
// shared signed 33x33 multiplier with registered product
// depends on gcl_pkg

module gcl_mul (
  input  logic                             clk_i,
  input  gcl_pkg::gcl_mul_req_t            req_i,
  output logic signed [2*gcl_pkg::MulW-1:0] prod_o
);
  import gcl_pkg::*;

  logic signed [2*MulW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= $signed(req_i.a) * $signed(req_i.b);
    end
  end

  assign prod_o = prod_q;

endmodule

[hdl/gcl_store.sv]
// model memories: class means and inverse covariance entries
// one write and one registered read per memory per cycle; depends on gcl_pkg

module gcl_store #(
  parameter int MAX_FEATURES = gcl_pkg::MaxFeaturesDef,
  parameter int MAX_CLASSES  = gcl_pkg::MaxClassesDef,
  localparam int MDepth = MAX_CLASSES * MAX_FEATURES,
  localparam int VDepth = MAX_CLASSES * MAX_FEATURES * MAX_FEATURES,
  localparam int MW = (MDepth > 1) ? $clog2(MDepth) : 1,
  localparam int VW = (VDepth > 1) ? $clog2(VDepth) : 1
) (
  input  logic                      clk_i,
  input  logic                      mean_we_i,
  input  logic [MW-1:0]             mean_waddr_i,
  input  logic                      cov_we_i,
  input  logic [VW-1:0]             cov_waddr_i,
  input  logic [gcl_pkg::DataW-1:0] wdata_i,
  input  logic [MW-1:0]             mean_raddr_i,
  input  logic [VW-1:0]             cov_raddr_i,
  output logic [gcl_pkg::DataW-1:0] mean_rdata_o,
  output logic [gcl_pkg::DataW-1:0] cov_rdata_o
);
  import gcl_pkg::*;

  logic [DataW-1:0] mean_mem [MDepth];
  logic [DataW-1:0] cov_mem  [VDepth];

  always_ff @(posedge clk_i) begin
    if (mean_we_i) begin
      mean_mem[mean_waddr_i] <= wdata_i;
    end
    mean_rdata_o <= mean_mem[mean_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (cov_we_i) begin
      cov_mem[cov_waddr_i] <= wdata_i;
    end
    cov_rdata_o <= cov_mem[cov_raddr_i];
  end

endmodule

[hdl/gaussian_class_likelihood.sv]
// model loads and non-final features are accepted while idle; the final feature starts a run
// over all classes in use, each class computed in turn on
// one shared 33x33 multiplier; in_ready_o is low for the whole run of all classes
// results leave through one output register, a class waits there only while it stalls
// reset (rst_ni low, asynchronous): idle, no result pending, both registers back to 8;
// model memories and sample buffer hold no reset value
module gaussian_class_likelihood #(
  parameter int MAX_FEATURES = gcl_pkg::MaxFeaturesDef,
  parameter int MAX_CLASSES  = gcl_pkg::MaxClassesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gcl_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [gcl_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  req_type_i,
  input  logic [2:0]                  class_index_i,
  input  logic [2:0]                  row_index_i,
  input  logic [2:0]                  col_index_i,
  input  logic signed [31:0]          value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  out_class_o,
  output logic [47:0]                 likelihood_o,
  output logic                        saturated_o,
  output logic                        last_class_o
);
  import gcl_pkg::*;

  localparam int MDepth = MAX_CLASSES * MAX_FEATURES;
  localparam int VDepth = MAX_CLASSES * MAX_FEATURES * MAX_FEATURES;
  localparam int MW  = (MDepth > 1) ? $clog2(MDepth) : 1;
  localparam int VW  = (VDepth > 1) ? $clog2(VDepth) : 1;
  localparam int FIW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int CIW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int TW  = 52;  // room for sixteen q16.16 product terms
  localparam int QW  = 52;
  localparam logic [4:0] MaxF5 = 5'(MAX_FEATURES);
  localparam logic [4:0] MaxC5 = 5'(MAX_CLASSES);

  // sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DIFF    = 3'd1;
  localparam logic [2:0] S_TMAC    = 3'd2;
  localparam logic [2:0] S_QMUL    = 3'd3;
  localparam logic [2:0] S_EXPINIT = 3'd4;
  localparam logic [2:0] S_EXP     = 3'd5;
  localparam logic [2:0] S_LIK     = 3'd6;

  // control state
  logic [2:0]         state_q, state_d;
  logic [1:0]         ph_q, ph_d;
  logic [FIW-1:0]     i_q, i_d, j_q, j_d;
  logic [CIW-1:0]     c_q, c_d;
  logic [ExpBitW-1:0] bit_q, bit_d;
  logic [1:0]         part_q, part_d;
  logic               sat_q, sat_d;
  logic [CfgW-1:0]    cfg_nf_q, cfg_nc_q;
  logic               out_valid_q, out_valid_d;

  // datapath state
  logic signed [TW-1:0] t_q, t_d;
  logic signed [QW-1:0] q_q, q_d;
  logic [63:0]          e_q, e_d;
  logic [65:0]          acc_q, acc_d;
  logic [ExpBits-1:0]   qb_q, qb_d;
  logic signed [31:0]   d_q [MAX_FEATURES];
  logic [31:0]          sample_q [MAX_FEATURES];
  logic [31:0]          scale_q [MAX_CLASSES];
  logic [2:0]           out_class_q;
  logic [LikW-1:0]      lik_q;
  logic                 out_sat_q, out_last_q;

  logic [4:0] nf_eff, nc_eff;
  logic       i_last, j_last, c_last;

  // effective counts, clamped to 1..max
  always_comb begin
    if (cfg_nf_q == '0) begin
      nf_eff = 5'd1;
    end else if ({1'b0, cfg_nf_q} > MaxF5) begin
      nf_eff = MaxF5;
    end else begin
      nf_eff = {1'b0, cfg_nf_q};
    end
    if (cfg_nc_q == '0) begin
      nc_eff = 5'd1;
    end else if ({1'b0, cfg_nc_q} > MaxC5) begin
      nc_eff = MaxC5;
    end else begin
      nc_eff = {1'b0, cfg_nc_q};
    end
  end

  assign i_last = (5'(i_q) == nf_eff - 5'd1);
  assign j_last = (5'(j_q) == nf_eff - 5'd1);
  assign c_last = (5'(c_q) == nc_eff - 5'd1);

  // input transaction decode
  logic in_acc, cls_ok, row_ok, col_ok;
  logic mean_we, cov_we, scale_we, smp_we, start;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign cls_ok     = ({2'b0, class_index_i} < MaxC5);
  assign row_ok     = ({2'b0, row_index_i} < MaxF5);
  assign col_ok     = ({2'b0, col_index_i} < MaxF5);
  assign mean_we    = in_acc && (req_type_i == ReqMean) && cls_ok && row_ok;
  assign cov_we     = in_acc && (req_type_i == ReqCov) && cls_ok && row_ok && col_ok;
  assign scale_we   = in_acc && (req_type_i == ReqScale) && cls_ok && row_ok;
  assign smp_we     = in_acc && (req_type_i == ReqFeature) && row_ok;
  assign start      = smp_we && ({2'b0, row_index_i} == nf_eff - 5'd1);

  // model memories
  logic [MW-1:0]    mean_waddr, mean_raddr;
  logic [VW-1:0]    cov_waddr, cov_raddr;
  logic [DataW-1:0] mean_rd, cov_rd;

  assign mean_waddr = MW'(int'(class_index_i) * MAX_FEATURES + int'(row_index_i));
  assign cov_waddr  = VW'((int'(class_index_i) * MAX_FEATURES + int'(row_index_i))
                          * MAX_FEATURES + int'(col_index_i));
  assign mean_raddr = MW'(int'(c_q) * MAX_FEATURES + int'(i_q));
  assign cov_raddr  = VW'((int'(c_q) * MAX_FEATURES + int'(i_q)) * MAX_FEATURES + int'(j_q));

  gcl_store #(
    .MAX_FEATURES (MAX_FEATURES),
    .MAX_CLASSES  (MAX_CLASSES)
  ) u_store (
    .clk_i        (clk_i),
    .mean_we_i    (mean_we),
    .mean_waddr_i (mean_waddr),
    .cov_we_i     (cov_we),
    .cov_waddr_i  (cov_waddr),
    .wdata_i      (value_i),
    .mean_raddr_i (mean_raddr),
    .cov_raddr_i  (cov_raddr),
    .mean_rdata_o (mean_rd),
    .cov_rdata_o  (cov_rd)
  );

  // shared multiplier
  gcl_mul_req_t             mul_req;
  logic signed [2*MulW-1:0] mul_p;

  gcl_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (mul_p)
  );

  // difference of sample and mean, clamped to 32 bits
  logic [31:0]        smp_rd;
  logic signed [32:0] diff;
  logic               diff_sat;
  logic signed [31:0] d_new, d_rd;

  assign smp_rd   = sample_q[i_q];
  assign diff     = $signed({smp_rd[31], smp_rd}) - $signed({mean_rd[31], mean_rd});
  assign diff_sat = (diff[32] != diff[31]);
  assign d_new    = diff_sat ? (diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : diff[31:0];
  assign d_rd     = d_q[(state_q == S_QMUL) ? j_q : i_q];

  // row accumulation and clamp, quadratic form accumulation
  logic signed [TW-1:0] t_sum;
  logic                 t_sat;
  logic signed [31:0]   t_clamp;
  logic signed [QW-1:0] q_sum;
  logic                 q_big;

  assign t_sum   = t_q + TW'(mul_p >>> 16);
  assign t_sat   = (t_sum[TW-1:31] != '0) && (t_sum[TW-1:31] != '1);
  assign t_clamp = t_sat ? (t_sum[TW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : t_sum[31:0];
  assign q_sum   = q_q + QW'(mul_p >>> 16);
  assign q_big   = (q_q[QW-2:ExpBits] != '0);

  logic [63:0] w_cur, prod_u;
  assign w_cur  = ExpWeights[bit_q];
  assign prod_u = mul_p[63:0];

  logic out_load;

  always_comb begin
    state_d     = state_q;
    ph_d        = ph_q;
    i_d         = i_q;
    j_d         = j_q;
    c_d         = c_q;
    bit_d       = bit_q;
    part_d      = part_q;
    sat_d       = sat_q;
    t_d         = t_q;
    q_d         = q_q;
    e_d         = e_q;
    acc_d       = acc_q;
    qb_d        = qb_q;
    out_load    = 1'b0;
    mul_req     = '0;
    out_valid_d = out_valid_q && !out_ready_i;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_DIFF;
          c_d     = '0;
          i_d     = '0;
          ph_d    = 2'd0;
          sat_d   = 1'b0;
        end
      end
      S_DIFF: begin
        // wait for mean read, then store clamped difference
        if (ph_q == 2'd0) begin
          ph_d = 2'd1;
        end else begin
          sat_d = sat_q | diff_sat;
          ph_d  = 2'd0;
          if (i_last) begin
            state_d = S_TMAC;
            i_d     = '0;
            j_d     = '0;
            t_d     = '0;
            q_d     = '0;
          end else begin
            i_d = i_q + 1'b1;
          end
        end
      end
      S_TMAC: begin
        if (ph_q == 2'd0) begin
          ph_d = 2'd1;
        end else if (ph_q == 2'd1) begin
          mul_req.en = 1'b1;
          mul_req.a  = {d_rd[31], d_rd};
          mul_req.b  = {cov_rd[31], cov_rd};
          ph_d       = 2'd2;
        end else begin
          ph_d = 2'd0;
          if (i_last) begin
            t_d     = {{(TW-32){t_clamp[31]}}, t_clamp};
            sat_d   = sat_q | t_sat;
            state_d = S_QMUL;
          end else begin
            t_d = t_sum;
            i_d = i_q + 1'b1;
          end
        end
      end
      S_QMUL: begin
        if (ph_q == 2'd0) begin
          mul_req.en = 1'b1;
          mul_req.a  = {t_q[31], t_q[31:0]};
          mul_req.b  = {d_rd[31], d_rd};
          ph_d       = 2'd1;
        end else begin
          q_d  = q_sum;
          ph_d = 2'd0;
          if (j_last) begin
            state_d = S_EXPINIT;
          end else begin
            j_d     = j_q + 1'b1;
            i_d     = '0;
            t_d     = '0;
            state_d = S_TMAC;
          end
        end
      end
      S_EXPINIT: begin
        // negative form counts as zero, a large one gives zero
        bit_d   = '0;
        part_d  = 2'd0;
        ph_d    = 2'd0;
        e_d     = '1;
        state_d = S_EXP;
        if (q_q[QW-1]) begin
          sat_d = 1'b1;
          qb_d  = '0;
        end else if (q_big) begin
          e_d  = '0;
          qb_d = '0;
        end else begin
          qb_d = q_q[ExpBits-1:0];
        end
      end
      S_EXP: begin
        // e = high half of e * w, four 32x32 partial products
        if (qb_q[bit_q] && (ph_q == 2'd0)) begin
          mul_req.en = 1'b1;
          mul_req.a  = {1'b0, (part_q[1] ? e_q[63:32] : e_q[31:0])};
          mul_req.b  = {1'b0, (part_q[0] ? w_cur[63:32] : w_cur[31:0])};
          ph_d       = 2'd1;
        end else begin
          ph_d = 2'd0;
          if (qb_q[bit_q]) begin
            part_d = part_q + 1'b1;
            case (part_q)
              2'd0:    acc_d = 66'(prod_u[63:32]);
              2'd1:    acc_d = acc_q + 66'(prod_u);
              2'd2:    acc_d = acc_q + 66'(prod_u);
              default: e_d   = 64'(acc_q >> 32) + prod_u;
            endcase
          end
          if (!qb_q[bit_q] || (part_q == 2'd3)) begin
            if (bit_q == ExpBitW'(ExpBits - 1)) begin
              state_d = S_LIK;
            end else begin
              bit_d = bit_q + 1'b1;
            end
          end
        end
      end
      S_LIK: begin
        if (ph_q == 2'd0) begin
          mul_req.en = 1'b1;
          mul_req.a  = {1'b0, scale_q[c_q]};
          mul_req.b  = {1'b0, e_q[63:32]};
          ph_d       = 2'd1;
        end else if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          ph_d        = 2'd0;
          if (c_last) begin
            state_d = S_IDLE;
          end else begin
            c_d     = c_q + 1'b1;
            i_d     = '0;
            sat_d   = 1'b0;
            state_d = S_DIFF;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ph_q        <= 2'd0;
      i_q         <= '0;
      j_q         <= '0;
      c_q         <= '0;
      bit_q       <= '0;
      part_q      <= 2'd0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      cfg_nf_q    <= CfgW'(8);
      cfg_nc_q    <= CfgW'(8);
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      i_q         <= i_d;
      j_q         <= j_d;
      c_q         <= c_d;
      bit_q       <= bit_d;
      part_q      <= part_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgFeatures: cfg_nf_q <= cfg_wdata_i;
          CfgClasses:  cfg_nc_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    t_q   <= t_d;
    q_q   <= q_d;
    e_q   <= e_d;
    acc_q <= acc_d;
    qb_q  <= qb_d;
    if (state_q == S_DIFF && ph_q == 2'd1) begin
      d_q[i_q] <= d_new;
    end
    if (smp_we) begin
      sample_q[FIW'(row_index_i)] <= value_i;
    end
    if (scale_we) begin
      scale_q[CIW'(class_index_i)] <= value_i;
    end
    if (out_load) begin
      out_class_q <= 3'(c_q);
      lik_q       <= mul_p[63:16];
      out_sat_q   <= sat_q;
      out_last_q  <= c_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_class_o  = out_class_q;
  assign likelihood_o = lik_q;
  assign saturated_o  = out_sat_q;
  assign last_class_o = out_last_q;

`ifndef SYNTH
  a_exp_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXP |-> bit_q < ExpBitW'(ExpBits))
    else $error("exp bit counter out of range");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TMAC || state_q == S_QMUL) |-> (5'(i_q) < nf_eff && 5'(j_q) < nf_eff))
    else $error("feature index beyond features in use");

  a_last_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_class_o) |-> out_class_o == 3'(nc_eff - 5'd1))
    else $error("last class flag on wrong class");
`endif

endmodule
